FILE: hw/rtl/rnct_pkg.sv
// Shared types, codes and constants for the radix node child table.
`timescale 1ns / 1ps

package rnct_pkg;

    localparam int KEY_W      = 8;
    localparam int KEY_SPACE  = 256;
    localparam int HANDLE_W   = 32;
    localparam int COUNT_W    = 9;
    localparam int CLASS_W    = 2;
    localparam int GRP_W      = 4;

    localparam logic KIND_FIND   = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_4   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_16  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_48  = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_256 = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd256;

    typedef struct packed {
        logic               found;
        logic               has_left;
        logic               duplicate;
        logic [CLASS_W-1:0] size_class;
        logic [COUNT_W-1:0] child_count;
        logic               is_full;
    } t_step;

    function automatic logic [COUNT_W-1:0] class_cap(input logic [CLASS_W-1:0] c);
        logic [COUNT_W-1:0] cap;
        unique case (c)
            CLASS_4:   cap = 9'd4;
            CLASS_16:  cap = 9'd16;
            CLASS_48:  cap = 9'd48;
            CLASS_256: cap = 9'd256;
            default:   cap = 9'd256;
        endcase
        return cap;
    endfunction

endpackage

FILE: hw/rtl/rnct_in_if.sv
// Input channel interface: find or insert words.
`timescale 1ns / 1ps

interface rnct_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [rnct_pkg::KEY_W-1:0]   key;
    logic [rnct_pkg::HANDLE_W-1:0] child_handle;

    modport source (output valid, output kind, output key, output child_handle,
                    input ready);
    modport sink   (input valid, input kind, input key, input child_handle,
                    output ready);
endinterface

FILE: hw/rtl/rnct_out_if.sv
// Output channel interface: result words.
`timescale 1ns / 1ps

interface rnct_out_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [rnct_pkg::HANDLE_W-1:0]  found_handle;
    logic                           has_left;
    logic [rnct_pkg::HANDLE_W-1:0]  left_handle;
    logic [rnct_pkg::CLASS_W-1:0]   size_class;
    logic [rnct_pkg::COUNT_W-1:0]   child_count;
    logic                           is_full;
    logic                           duplicate;

    modport source (output valid, output found, output found_handle, output has_left,
                    output left_handle, output size_class, output child_count,
                    output is_full, output duplicate, input ready);
    modport sink   (input valid, input found, input found_handle, input has_left,
                    input left_handle, input size_class, input child_count,
                    input is_full, input duplicate, output ready);
endinterface

FILE: hw/rtl/radix_node_child_table.sv
// Top level of the radix node child table: input, lookup and output stages.
//
//   channel | dir | modport | word
//   i_in    | in  | sink    | kind, key, child_handle
//   o_out   | out | source  | found, found_handle, has_left, left_handle,
//           |     |         | size_class, child_count, is_full, duplicate
//
// One word per cycle sustained while o_out is not stalled; a result passes the input register,
// the lookup stage with the registered read of the handle memory, and the output register.
// Reset clears the present map, count, class and full mark.
// An output stall fills the lookup stage and the input register, then drops ready.
`timescale 1ns / 1ps

module radix_node_child_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rnct_in_if.sink     i_in,
    rnct_out_if.source  o_out
);

    logic                          r_v0;
    logic                          r_kind;
    logic [rnct_pkg::KEY_W-1:0]    r_key;
    logic [rnct_pkg::HANDLE_W-1:0] r_handle;

    logic                          r_v1;
    rnct_pkg::t_step               r_step;

    logic                          r_ov;
    rnct_pkg::t_step               r_ostep;
    logic [rnct_pkg::HANDLE_W-1:0] r_found_handle;
    logic [rnct_pkg::HANDLE_W-1:0] r_left_handle;

    rnct_pkg::t_step               step;
    logic [rnct_pkg::HANDLE_W-1:0] rdata;
    logic                          mv0, mv1, take_in;

    assign mv1        = r_v1 && (!r_ov || o_out.ready);
    assign mv0        = r_v0 && (!r_v1 || mv1);
    assign i_in.ready = !r_v0 || mv0;
    assign take_in    = i_in.valid && i_in.ready;

    rnct_node u_node (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (mv0),
        .i_kind   (r_kind),
        .i_key    (r_key),
        .i_handle (r_handle),
        .o_step   (step),
        .o_rdata  (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (take_in) begin
                r_v0 <= 1'b1;
            end else if (mv0) begin
                r_v0 <= 1'b0;
            end
            if (mv0) begin
                r_v1 <= 1'b1;
            end else if (mv1) begin
                r_v1 <= 1'b0;
            end
            if (mv1) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_kind   <= i_in.kind;
            r_key    <= i_in.key;
            r_handle <= i_in.child_handle;
        end
        if (mv0) begin
            r_step <= step;
        end
        if (mv1) begin
            r_ostep        <= r_step;
            r_found_handle <= r_step.found ? rdata : '0;
            r_left_handle  <= r_step.has_left ? rdata : '0;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.found        = r_ostep.found;
    assign o_out.found_handle = r_found_handle;
    assign o_out.has_left     = r_ostep.has_left;
    assign o_out.left_handle  = r_left_handle;
    assign o_out.size_class   = r_ostep.size_class;
    assign o_out.child_count  = r_ostep.child_count;
    assign o_out.is_full      = r_ostep.is_full;
    assign o_out.duplicate    = r_ostep.duplicate;

`ifndef NO_ASSERTIONS
    a_full_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ostep.is_full) |->
        (r_ostep.child_count == rnct_pkg::class_cap(r_ostep.size_class)))
        else $error("full mark set with count below class capacity");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_ostep.found && (r_ostep.has_left || r_ostep.duplicate)))
        else $error("find and insert flags mixed in one word");

    a_dup_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ostep.duplicate) |-> (!r_ostep.has_left && r_left_handle == '0))
        else $error("duplicate insert reported a left neighbor");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_ov && !o_out.ready) |=> (r_v1 && $stable(r_step)))
        else $error("lookup stage lost its word during an output stall");
`endif

endmodule

FILE: hw/rtl/rnct_prio.sv
// Two-level priority encoder: largest present key below a given key.
`timescale 1ns / 1ps

module rnct_prio (
    input  logic [rnct_pkg::KEY_SPACE-1:0] i_map,
    input  logic [rnct_pkg::KEY_W-1:0]     i_key,
    output logic                           o_any,
    output logic [rnct_pkg::KEY_W-1:0]     o_idx
);

    localparam int GRPS = 1 << rnct_pkg::GRP_W;

    function automatic logic [3:0] hi16(input logic [15:0] v);
        logic [7:0] w8;
        logic [3:0] w4;
        logic [1:0] w2;
        logic [3:0] r;
        r[3] = |v[15:8];
        w8   = r[3] ? v[15:8] : v[7:0];
        r[2] = |w8[7:4];
        w4   = r[2] ? w8[7:4] : w8[3:0];
        r[1] = |w4[3:2];
        w2   = r[1] ? w4[3:2] : w4[1:0];
        r[0] = w2[1];
        return r;
    endfunction

    logic [rnct_pkg::KEY_SPACE-1:0] below;
    logic [GRPS-1:0]                g_any;
    logic [rnct_pkg::GRP_W-1:0]     grp;
    logic [15:0]                    sel;

    always_comb begin
        for (int i = 0; i < rnct_pkg::KEY_SPACE; i++) begin
            below[i] = i_map[i] && (rnct_pkg::KEY_W'(i) < i_key);
        end
        for (int g = 0; g < GRPS; g++) begin
            g_any[g] = |below[g*16 +: 16];
        end
    end

    assign grp   = hi16(g_any);
    assign sel   = below[{grp, 4'b0000} +: 16];
    assign o_any = |g_any;
    assign o_idx = {grp, hi16(sel)};

endmodule

FILE: hw/rtl/rnct_node.sv
// Node state: present map, counters, size class and the handle memory.
`timescale 1ns / 1ps

module rnct_node (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic                           i_kind,
    input  logic [rnct_pkg::KEY_W-1:0]     i_key,
    input  logic [rnct_pkg::HANDLE_W-1:0]  i_handle,
    output rnct_pkg::t_step                o_step,
    output logic [rnct_pkg::HANDLE_W-1:0]  o_rdata
);

    logic [rnct_pkg::KEY_SPACE-1:0] r_map;
    logic [rnct_pkg::HANDLE_W-1:0]  mem [rnct_pkg::KEY_SPACE];
    logic [rnct_pkg::HANDLE_W-1:0]  r_rdata;
    logic [rnct_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [rnct_pkg::CLASS_W-1:0]   r_class, n_class;
    logic                           r_full, n_full;

    logic                           in_space;
    logic                           present;
    logic                           is_ins;
    logic                           do_ins;
    logic                           left_any;
    logic [rnct_pkg::KEY_W-1:0]     left_idx;
    logic [rnct_pkg::KEY_W-1:0]     rd_addr;
    logic [rnct_pkg::CLASS_W-1:0]   prom_class;
    logic                           prom_full;

    rnct_prio u_prio (
        .i_map (r_map),
        .i_key (i_key),
        .o_any (left_any),
        .o_idx (left_idx)
    );

    assign in_space = {1'b0, i_key} < rnct_pkg::COUNT_W'(rnct_pkg::KEY_SPACE);
    assign present  = r_map[i_key];
    assign is_ins   = (i_kind == rnct_pkg::KIND_INSERT);
    assign do_ins   = is_ins && in_space && !present;
    assign rd_addr  = is_ins ? left_idx : i_key;

    always_comb begin
        prom_class = r_class;
        prom_full  = r_full;
        if (r_full) begin
            if (r_class != rnct_pkg::CLASS_256) begin
                prom_class = r_class + 2'd1;
            end
            prom_full = 1'b0;
        end
        n_count = (r_count < rnct_pkg::COUNT_MAX) ? r_count + 9'd1 : r_count;
        n_class = prom_class;
        n_full  = (n_count == rnct_pkg::class_cap(prom_class)) ? 1'b1 : prom_full;
        if (!do_ins) begin
            n_count = r_count;
            n_class = r_class;
            n_full  = r_full;
        end
    end

    always_comb begin
        o_step.found       = !is_ins && in_space && present;
        o_step.has_left    = do_ins && left_any;
        o_step.duplicate   = is_ins && in_space && present;
        o_step.size_class  = n_class;
        o_step.child_count = n_count;
        o_step.is_full     = n_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_count <= '0;
            r_class <= rnct_pkg::CLASS_4;
            r_full  <= 1'b0;
        end else if (i_fire) begin
            if (do_ins) begin
                r_map[i_key] <= 1'b1;
            end
            r_count <= n_count;
            r_class <= n_class;
            r_full  <= n_full;
        end
    end

    // insert reads the left neighbor, which differs from the key written whenever one exists
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (do_ins) begin
                mem[i_key] <= i_handle;
            end
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: dv/tb_top.sv
// Testbench for the radix node child table: directed table, then random words, vs. a predictor.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic                          found;
        logic [rnct_pkg::HANDLE_W-1:0] found_handle;
        logic                          has_left;
        logic [rnct_pkg::HANDLE_W-1:0] left_handle;
        logic [rnct_pkg::CLASS_W-1:0]  size_class;
        logic [rnct_pkg::COUNT_W-1:0]  child_count;
        logic                          is_full;
        logic                          duplicate;
    } t_node_result;

    typedef struct packed {
        logic                          kind;
        logic [rnct_pkg::KEY_W-1:0]    key;
        logic [rnct_pkg::HANDLE_W-1:0] handle;
        logic                          typed;
        t_node_result                  want;
    } t_word_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rnct_in_if  in_ch ();
    rnct_out_if out_ch ();

    radix_node_child_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predicted node state
    logic                          node_present [rnct_pkg::KEY_SPACE];
    logic [rnct_pkg::HANDLE_W-1:0] node_handle [rnct_pkg::KEY_SPACE];
    logic [rnct_pkg::COUNT_W-1:0]  node_count;
    logic [rnct_pkg::CLASS_W-1:0]  node_class;
    logic                          node_full;

    // keys the stimulus has inserted so far
    logic                key_taken [rnct_pkg::KEY_SPACE];
    int                  taken_cnt;

    t_node_result        pending_results [$];
    t_word_row           directed_rows [$];
    int                  mismatch_cnt;
    bit                  tx_calm;
    bit                  rx_calm;
    int                  rx_hold;
    int                  rx_gap;

    function automatic t_node_result node_apply(input logic kind,
                                                input logic [rnct_pkg::KEY_W-1:0] key,
                                                input logic [rnct_pkg::HANDLE_W-1:0] hnd);
        t_node_result                 res;
        logic [rnct_pkg::COUNT_W-1:0] cap;
        res = '0;
        if (kind == rnct_pkg::KIND_FIND) begin
            if (node_present[key]) begin
                res.found        = 1'b1;
                res.found_handle = node_handle[key];
            end
        end else if (node_present[key]) begin
            res.duplicate = 1'b1;
        end else begin
            if (node_full) begin
                if (node_class != rnct_pkg::CLASS_256)
                    node_class = node_class + 2'd1;
                node_full = 1'b0;
            end
            for (int i = int'(key) - 1; i >= 0 && !res.has_left; i--) begin
                if (node_present[i]) begin
                    res.has_left    = 1'b1;
                    res.left_handle = node_handle[i];
                end
            end
            node_present[key] = 1'b1;
            node_handle[key]  = hnd;
            if (node_count < rnct_pkg::COUNT_MAX)
                node_count = node_count + 9'd1;
            case (node_class)
                rnct_pkg::CLASS_4:  cap = 9'd4;
                rnct_pkg::CLASS_16: cap = 9'd16;
                rnct_pkg::CLASS_48: cap = 9'd48;
                default:            cap = 9'd256;
            endcase
            if (node_count == cap)
                node_full = 1'b1;
        end
        res.size_class  = node_class;
        res.child_count = node_count;
        res.is_full     = node_full;
        return res;
    endfunction

    function automatic t_node_result outcome(input logic found, input logic [31:0] fh,
                                             input logic hl, input logic [31:0] lh,
                                             input logic [rnct_pkg::CLASS_W-1:0] cls,
                                             input logic [rnct_pkg::COUNT_W-1:0] cnt,
                                             input logic full, input logic dup);
        t_node_result r;
        r.found        = found;
        r.found_handle = fh;
        r.has_left     = hl;
        r.left_handle  = lh;
        r.size_class   = cls;
        r.child_count  = cnt;
        r.is_full      = full;
        r.duplicate    = dup;
        return r;
    endfunction

    function automatic t_word_row word_row(input logic kind,
                                           input logic [rnct_pkg::KEY_W-1:0] key,
                                           input logic [rnct_pkg::HANDLE_W-1:0] hnd,
                                           input logic typed,
                                           input t_node_result want);
        t_word_row r;
        r.kind   = kind;
        r.key    = key;
        r.handle = hnd;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    function automatic int gap_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [rnct_pkg::KEY_W-1:0] pick_key(input logic want_taken);
        logic [rnct_pkg::KEY_W-1:0] k;
        k = rnct_pkg::KEY_W'($urandom_range(0, rnct_pkg::KEY_SPACE - 1));
        for (int i = 0; i < rnct_pkg::KEY_SPACE; i++) begin
            if (key_taken[k] == want_taken)
                return k;
            k = k + 8'd1;
        end
        return k;
    endfunction

    task automatic note_insert(input logic [rnct_pkg::KEY_W-1:0] key);
        if (!key_taken[key]) begin
            key_taken[key] = 1'b1;
            taken_cnt++;
        end
    endtask

    task automatic send_word(input logic kind, input logic [rnct_pkg::KEY_W-1:0] key,
                             input logic [rnct_pkg::HANDLE_W-1:0] hnd, input logic typed,
                             input t_node_result want);
        t_node_result pred;
        int           g;
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.key          <= key;
        in_ch.child_handle <= hnd;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pred = node_apply(kind, key, hnd);
        pending_results.push_back(typed ? want : pred);
        g = gap_len(tx_calm);
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // result side: random stalls, compare against oldest expectation
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0)
            rx_calm <= !rx_calm;
        if (rx_hold > 0) begin
            rx_hold      <= rx_hold - 1;
            out_ch.ready <= 1'b0;
        end else begin
            rx_gap = gap_len(rx_calm);
            out_ch.ready <= (rx_gap == 0);
            rx_hold      <= (rx_gap > 0) ? rx_gap - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        t_node_result exp_r;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                $display("%0t unexpected word: expected none, actual found=%b count=%0d",
                         $time, out_ch.found, out_ch.child_count);
            end else begin
                exp_r = pending_results.pop_front();
                check_field("found",        32'(exp_r.found),       32'(out_ch.found));
                check_field("found_handle", exp_r.found_handle,     out_ch.found_handle);
                check_field("has_left",     32'(exp_r.has_left),    32'(out_ch.has_left));
                check_field("left_handle",  exp_r.left_handle,      out_ch.left_handle);
                check_field("size_class",   32'(exp_r.size_class),  32'(out_ch.size_class));
                check_field("child_count",  32'(exp_r.child_count), 32'(out_ch.child_count));
                check_field("is_full",      32'(exp_r.is_full),     32'(out_ch.is_full));
                check_field("duplicate",    32'(exp_r.duplicate),   32'(out_ch.duplicate));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic                       kind;
        logic [rnct_pkg::KEY_W-1:0] key;
        logic [31:0]                hnd;
        int                         r;
        in_ch.valid        = 1'b0;
        in_ch.kind         = rnct_pkg::KIND_FIND;
        in_ch.key          = '0;
        in_ch.child_handle = '0;
        out_ch.ready       = 1'b0;
        mismatch_cnt       = 0;
        taken_cnt          = 0;
        tx_calm            = 1'b0;
        rx_calm            = 1'b0;
        rx_hold            = 0;
        node_count         = '0;
        node_class         = rnct_pkg::CLASS_4;
        node_full          = 1'b0;
        for (int i = 0; i < rnct_pkg::KEY_SPACE; i++) begin
            node_present[i] = 1'b0;
            node_handle[i]  = '0;
            key_taken[i]    = 1'b0;
        end

        // empty node, extremes, duplicates, full mark, promotion
        directed_rows.push_back(word_row(rnct_pkg::KIND_FIND, 8'd0, 32'h0, 1'b1,
            outcome(1'b0, 32'h0, 1'b0, 32'h0, rnct_pkg::CLASS_4, 9'd0, 1'b0, 1'b0)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_FIND, 8'd255, 32'hFFFF_FFFF, 1'b1,
            outcome(1'b0, 32'h0, 1'b0, 32'h0, rnct_pkg::CLASS_4, 9'd0, 1'b0, 1'b0)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_INSERT, 8'd128, 32'hFFFF_FFFF, 1'b1,
            outcome(1'b0, 32'h0, 1'b0, 32'h0, rnct_pkg::CLASS_4, 9'd1, 1'b0, 1'b0)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_INSERT, 8'd128, 32'h0, 1'b1,
            outcome(1'b0, 32'h0, 1'b0, 32'h0, rnct_pkg::CLASS_4, 9'd1, 1'b0, 1'b1)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_FIND, 8'd128, 32'h0, 1'b1,
            outcome(1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, rnct_pkg::CLASS_4, 9'd1, 1'b0, 1'b0)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_INSERT, 8'd0, 32'h0, 1'b1,
            outcome(1'b0, 32'h0, 1'b0, 32'h0, rnct_pkg::CLASS_4, 9'd2, 1'b0, 1'b0)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_INSERT, 8'd255, 32'hA5A5_A5A5, 1'b1,
            outcome(1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF, rnct_pkg::CLASS_4, 9'd3, 1'b0, 1'b0)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_INSERT, 8'd200, 32'h5A5A_5A5A, 1'b1,
            outcome(1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF, rnct_pkg::CLASS_4, 9'd4, 1'b1, 1'b0)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_INSERT, 8'd200, 32'h0, 1'b1,
            outcome(1'b0, 32'h0, 1'b0, 32'h0, rnct_pkg::CLASS_4, 9'd4, 1'b1, 1'b1)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_FIND, 8'd0, 32'h0, 1'b1,
            outcome(1'b1, 32'h0, 1'b0, 32'h0, rnct_pkg::CLASS_4, 9'd4, 1'b1, 1'b0)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_INSERT, 8'd1, 32'h1234_5678, 1'b1,
            outcome(1'b0, 32'h0, 1'b1, 32'h0, rnct_pkg::CLASS_16, 9'd5, 1'b0, 1'b0)));
        directed_rows.push_back(word_row(rnct_pkg::KIND_FIND, 8'd1, 32'h0, 1'b0, '0));
        directed_rows.push_back(word_row(rnct_pkg::KIND_FIND, 8'd2, 32'h0, 1'b0, '0));
        directed_rows.push_back(word_row(rnct_pkg::KIND_INSERT, 8'd254, 32'h8000_0001, 1'b0, '0));
        directed_rows.push_back(word_row(rnct_pkg::KIND_FIND, 8'd255, 32'h0, 1'b0, '0));
        directed_rows.push_back(word_row(rnct_pkg::KIND_INSERT, 8'd127, 32'h7FFF_FFFE, 1'b0, '0));
        directed_rows.push_back(word_row(rnct_pkg::KIND_FIND, 8'd200, 32'h0, 1'b0, '0));
        directed_rows.push_back(word_row(rnct_pkg::KIND_FIND, 8'd254, 32'h0, 1'b0, '0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == rnct_pkg::KIND_INSERT)
                note_insert(directed_rows[i].key);
            send_word(directed_rows[i].kind, directed_rows[i].key,
                      directed_rows[i].handle, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        // mostly fresh inserts and finds of present keys, for 1600 words
        for (int n = 0; n < 1600; n++) begin
            if ($urandom_range(0, 149) == 0)
                tx_calm = !tx_calm;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                kind = rnct_pkg::KIND_INSERT;
                if (taken_cnt < rnct_pkg::KEY_SPACE && $urandom_range(0, 3) != 0)
                    key = pick_key(1'b0);
                else
                    key = rnct_pkg::KEY_W'($urandom_range(0, rnct_pkg::KEY_SPACE - 1));
                case ($urandom_range(0, 19))
                    0:       hnd = 32'h0;
                    1:       hnd = 32'hFFFF_FFFF;
                    default: hnd = $urandom;
                endcase
                note_insert(key);
            end else begin
                kind = rnct_pkg::KIND_FIND;
                if (taken_cnt > 0 && $urandom_range(0, 9) < 7)
                    key = pick_key(1'b1);
                else
                    key = rnct_pkg::KEY_W'($urandom_range(0, rnct_pkg::KEY_SPACE - 1));
                hnd = $urandom;
            end
            send_word(kind, key, hnd, 1'b0, '0);
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
